// ----- hw/rtl/sti_pkg.sv -----
// ---------------------------------------------------------------------------
// Session table intake package
// Shared types and constants of the session table intake block.
// ---------------------------------------------------------------------------
`default_nettype none
package sti_pkg;

	localparam int unsigned SLOTS_DEFAULT = 16;
	localparam int unsigned SLOT_W = 8;
	localparam int unsigned COUNT_W = 9;
	localparam logic [31:0] TIMEOUT_RESET = 32'd30000;
	localparam logic [63:0] NEXT_ID_RESET = 64'd1;

	localparam logic [1:0] REQ_INGEST = 2'd0;
	localparam logic [1:0] REQ_RELEASE = 2'd1;
	localparam logic [1:0] REQ_EXPIRE = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [63:0] sess_id;
		logic [31:0] pkt_ver;
		logic [7:0] pkt_form;
		logic [31:0] client_ip;
		logic [15:0] src_port;
		logic encrypted;
		logic [63:0] now_ms;
	} req_t;

	typedef struct packed {
		logic ok;
		logic [63:0] resolved_sid;
		logic synthetic;
		logic [7:0] slot_index;
		logic [8:0] expired_count;
		logic [8:0] active_count;
	} rsp_t;

	typedef struct packed {
		logic cli_f;
		logic [SLOT_W-1:0] cli_i;
		logic [63:0] cli_srv;
		logic sid_f;
		logic [SLOT_W-1:0] sid_i;
		logic raw_f;
		logic [SLOT_W-1:0] raw_i;
		logic [63:0] raw_srv;
		logic free_f;
		logic [SLOT_W-1:0] free_i;
		logic [COUNT_W-1:0] exp_cnt;
	} tok_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_INGEST,
		WR_RELEASE,
		WR_EXPIRE
	} wr_op_t;

	typedef struct packed {
		wr_op_t op;
		logic [SLOT_W-1:0] idx;
		logic fresh;
		logic [63:0] srv;
		logic [63:0] cli;
		logic [63:0] expiry;
	} wr_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sti_cell.sv -----
// ---------------------------------------------------------------------------
// Session table cell
// Holds one table entry, merges its match flags into the passing token.
// ---------------------------------------------------------------------------
`default_nettype none
module sti_cell #(
	parameter int unsigned INDEX = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire sti_pkg::req_t req,
	input wire sti_pkg::wr_t wr,
	input wire sti_pkg::tok_t tok_in,
	output sti_pkg::tok_t tok_out
);

	localparam logic [sti_pkg::SLOT_W-1:0] MY_IDX = sti_pkg::SLOT_W'(INDEX);

	logic act_q;
	logic [63:0] srv_q;
	logic [63:0] cli_q;
	logic [31:0] addr_q;
	logic [15:0] port_q;
	logic enc_q;
	logic [31:0] ver_q;
	logic [7:0] form_q;
	logic [63:0] exp_q;
	sti_pkg::tok_t tok_q;
	sti_pkg::tok_t tok_n;

	logic cli_hit, sid_hit, raw_hit, exp_hit, sel;

	assign cli_hit = act_q && cli_q == req.sess_id && ver_q == req.pkt_ver
		&& form_q == req.pkt_form;
	assign sid_hit = act_q && srv_q == req.sess_id;
	assign raw_hit = act_q && ver_q == 32'd0 && addr_q == req.client_ip;
	assign exp_hit = act_q && exp_q != 64'd0 && exp_q <= req.now_ms;
	assign sel = wr.idx == MY_IDX;
	assign tok_out = tok_q;

	always_comb begin
		tok_n = tok_in;
		if (!tok_in.cli_f && cli_hit) begin
			tok_n.cli_f = 1'b1;
			tok_n.cli_i = MY_IDX;
			tok_n.cli_srv = srv_q;
		end
		if (!tok_in.sid_f && sid_hit) begin
			tok_n.sid_f = 1'b1;
			tok_n.sid_i = MY_IDX;
		end
		if (!tok_in.raw_f && raw_hit) begin
			tok_n.raw_f = 1'b1;
			tok_n.raw_i = MY_IDX;
			tok_n.raw_srv = srv_q;
		end
		if (!tok_in.free_f && !act_q) begin
			tok_n.free_f = 1'b1;
			tok_n.free_i = MY_IDX;
		end
		tok_n.exp_cnt = tok_in.exp_cnt + sti_pkg::COUNT_W'(exp_hit);
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_n;
		if (wr.op == sti_pkg::WR_INGEST && sel) begin
			if (wr.fresh) begin
				srv_q <= wr.srv;
				cli_q <= wr.cli;
			end
			ver_q <= req.pkt_ver;
			form_q <= req.pkt_form;
			addr_q <= req.client_ip;
			port_q <= req.src_port;
			enc_q <= req.encrypted;
			exp_q <= wr.expiry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			unique case (wr.op)
				sti_pkg::WR_INGEST: if (sel) act_q <= 1'b1;
				sti_pkg::WR_RELEASE: if (sel) act_q <= 1'b0;
				sti_pkg::WR_EXPIRE: if (exp_hit) act_q <= 1'b0;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/sti_apb_regs.sv -----
// ---------------------------------------------------------------------------
// Session table configuration registers
// APB-style register file for mode and timeout.
// ---------------------------------------------------------------------------
`default_nettype none
module sti_apb_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic mode,
	output logic [31:0] timeout
);

	logic mode_q;
	logic [31:0] timeout_q;

	assign pready = 1'b1;
	assign mode = mode_q;
	assign timeout = timeout_q;
	assign prdata = paddr[2] ? timeout_q : {31'd0, mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			timeout_q <= sti_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) timeout_q <= pwdata;
			else mode_q <= pwdata[0];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/session_table_intake_core.sv -----
// ---------------------------------------------------------------------------
// Session table intake core
// A request accepted at one clock edge passes through the scan state, while the
// match token walks the chain of slot cells, and the write-back state; its
// result beat is then shown as the done strobe. A new start is taken at the
// edge that ends the done strobe, so the next request is not accepted before
// the last one has delivered its result.
// Reset frees every slot at once; the receiver cannot stall the result.
// ---------------------------------------------------------------------------
`default_nettype none
module session_table_intake_core #(
	parameter int unsigned TABLE_SLOTS = sti_pkg::SLOTS_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire sti_pkg::req_t req,
	output logic done,
	output sti_pkg::rsp_t rsp,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int unsigned CNT_W = TABLE_SLOTS > 1 ? $clog2(TABLE_SLOTS) : 1;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(TABLE_SLOTS - 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	sti_pkg::req_t req_q;
	logic [63:0] next_id_q;
	logic [8:0] live_q;
	logic done_q;
	sti_pkg::rsp_t rsp_q;
	logic mode;
	logic [31:0] timeout;

	sti_pkg::tok_t tok [TABLE_SLOTS+1];
	sti_pkg::tok_t fin;
	sti_pkg::wr_t wr;

	logic sid_nz, hit_c, hit_s, hit_r, hit, use_cnt;
	logic [63:0] new_srv, ninc, next_new, hit_srv;
	sti_pkg::rsp_t rsp_n;
	logic [8:0] live_n;
	logic [63:0] next_n;

	sti_apb_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.mode(mode), .timeout(timeout)
	);

	assign tok[0] = '0;

	for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
		sti_cell #(.INDEX(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .req(req_q), .wr(wr),
			.tok_in(tok[g]), .tok_out(tok[g+1])
		);
	end

	assign fin = tok[TABLE_SLOTS];
	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp = rsp_q;

	always_comb begin
		sid_nz = req_q.sess_id != 64'd0;
		hit_c = mode && sid_nz && fin.cli_f;
		hit_s = !mode && sid_nz && fin.sid_f;
		hit_r = req_q.pkt_ver == 32'd0 && req_q.client_ip != 32'd0 && fin.raw_f;
		hit = hit_c || hit_s || hit_r;
		use_cnt = mode || !sid_nz;
		new_srv = use_cnt ? next_id_q : req_q.sess_id;
		ninc = use_cnt ? next_id_q + 64'd1 : next_id_q;
		next_new = (new_srv >= ninc) ? new_srv + 64'd1 : ninc;
		hit_srv = hit_c ? fin.cli_srv : (hit_s ? req_q.sess_id : fin.raw_srv);
		wr = '0;
		wr.op = sti_pkg::WR_NONE;
		wr.srv = new_srv;
		wr.cli = mode ? (sid_nz ? req_q.sess_id : new_srv) : 64'd0;
		wr.expiry = req_q.now_ms + 64'(timeout);
		rsp_n = '0;
		live_n = live_q;
		next_n = next_id_q;
		case (req_q.req_type)
			sti_pkg::REQ_INGEST: begin
				if (hit || fin.free_f) begin
					wr.op = sti_pkg::WR_INGEST;
					wr.fresh = !hit;
					wr.idx = hit_c ? fin.cli_i : (hit_s ? fin.sid_i :
						(hit_r ? fin.raw_i : fin.free_i));
					rsp_n.ok = 1'b1;
					rsp_n.synthetic = !sid_nz;
					rsp_n.slot_index = wr.idx;
					if (!hit) begin
						live_n = live_q + 9'd1;
						next_n = next_new;
					end
					rsp_n.resolved_sid = use_cnt ? (hit ? hit_srv : new_srv)
						: req_q.sess_id;
				end
			end
			sti_pkg::REQ_RELEASE: begin
				if (sid_nz && fin.sid_f) begin
					wr.op = sti_pkg::WR_RELEASE;
					wr.idx = fin.sid_i;
					rsp_n.ok = 1'b1;
					rsp_n.slot_index = fin.sid_i;
					live_n = live_q - 9'd1;
				end
			end
			sti_pkg::REQ_EXPIRE: begin
				wr.op = sti_pkg::WR_EXPIRE;
				rsp_n.ok = 1'b1;
				rsp_n.expired_count = fin.exp_cnt;
				live_n = live_q - fin.exp_cnt;
			end
			default: ;
		endcase
		rsp_n.active_count = live_n;
		if (state_q != S_WRITE) wr.op = sti_pkg::WR_NONE;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) req_q <= req;
		if (state_q == S_WRITE) rsp_q <= rsp_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			next_id_q <= sti_pkg::NEXT_ID_RESET;
			live_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						cnt_q <= '0;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == LAST) state_q <= S_WRITE;
				end
				S_WRITE: begin
					state_q <= S_IDLE;
					done_q <= 1'b1;
					live_q <= live_n;
					next_id_q <= next_n;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sim/tb_session_table_intake_core.sv -----
// ---------------------------------------------------------------------------
// Session table intake core testbench
// Drives ingest, release and expire requests through the command port while
// the register port switches between key modes and timeouts. A scoreboard
// keeps its own copy of the session table, predicts each result beat and
// compares it field by field with what the block delivers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_session_table_intake_core;

	localparam int unsigned SLOTS = 16;
	localparam int unsigned IDLE_LIMIT = 4000;
	localparam logic [2:0] ADDR_MODE = 3'd0;
	localparam logic [2:0] ADDR_TIMEOUT = 3'd4;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	class session_scoreboard;
		logic mode;
		logic [31:0] tmo;
		logic act [SLOTS];
		logic [63:0] srv [SLOTS];
		logic [63:0] cli [SLOTS];
		logic [31:0] addr [SLOTS];
		logic [15:0] port [SLOTS];
		logic enc [SLOTS];
		logic [31:0] ver [SLOTS];
		logic [7:0] form [SLOTS];
		logic [63:0] expiry [SLOTS];
		logic [63:0] next_sid;
		logic [8:0] live;
		sti_pkg::rsp_t awaited [$];
		int errors;

		function new();
			mode = 1'b0;
			tmo = sti_pkg::TIMEOUT_RESET;
			next_sid = sti_pkg::NEXT_ID_RESET;
			live = '0;
			errors = 0;
			for (int i = 0; i < SLOTS; i++) clear_slot(i);
		endfunction

		function void clear_slot(int i);
			act[i] = 1'b0;
			srv[i] = '0;
			cli[i] = '0;
			addr[i] = '0;
			port[i] = '0;
			enc[i] = 1'b0;
			ver[i] = '0;
			form[i] = '0;
			expiry[i] = '0;
		endfunction

		function void vacate(int i);
			if (act[i]) begin
				clear_slot(i);
				if (live != 0) live--;
			end
		endfunction

		function int lookup(sti_pkg::req_t r);
			if (mode && r.sess_id != 0) begin
				for (int i = 0; i < SLOTS; i++)
					if (act[i] && cli[i] == r.sess_id && ver[i] == r.pkt_ver &&
						form[i] == r.pkt_form) return i;
			end
			if (!mode && r.sess_id != 0) begin
				for (int i = 0; i < SLOTS; i++)
					if (act[i] && srv[i] == r.sess_id) return i;
			end
			if (r.pkt_ver == 0 && r.client_ip != 0) begin
				for (int i = 0; i < SLOTS; i++)
					if (act[i] && ver[i] == 0 && addr[i] == r.client_ip) return i;
			end
			return -1;
		endfunction

		function void note_request(sti_pkg::req_t r);
			sti_pkg::rsp_t e;
			int s;
			logic [63:0] sv;
			e = '0;
			case (r.req_type)
				sti_pkg::REQ_INGEST: begin
					s = lookup(r);
					if (s < 0) begin
						for (int i = 0; i < SLOTS; i++)
							if (!act[i]) begin
								s = i;
								break;
							end
						if (s >= 0) begin
							if (mode) begin
								sv = next_sid;
								next_sid = next_sid + 1;
								cli[s] = (r.sess_id != 0) ? r.sess_id : sv;
							end else begin
								if (r.sess_id != 0) begin
									sv = r.sess_id;
								end else begin
									sv = next_sid;
									next_sid = next_sid + 1;
								end
								cli[s] = '0;
							end
							if (sv >= next_sid) next_sid = sv + 1;
							srv[s] = sv;
							act[s] = 1'b1;
							live++;
						end
					end
					if (s >= 0) begin
						ver[s] = r.pkt_ver;
						form[s] = r.pkt_form;
						addr[s] = r.client_ip;
						port[s] = r.src_port;
						enc[s] = r.encrypted;
						expiry[s] = r.now_ms + {32'd0, tmo};
						e.ok = 1'b1;
						e.synthetic = (r.sess_id == 0);
						e.resolved_sid = (mode || r.sess_id == 0) ? srv[s] : r.sess_id;
						e.slot_index = s[7:0];
					end
				end
				sti_pkg::REQ_RELEASE: begin
					if (r.sess_id != 0) begin
						for (int i = 0; i < SLOTS; i++)
							if (act[i] && srv[i] == r.sess_id) begin
								vacate(i);
								e.ok = 1'b1;
								e.slot_index = i[7:0];
								break;
							end
					end
				end
				sti_pkg::REQ_EXPIRE: begin
					for (int i = 0; i < SLOTS; i++)
						if (act[i] && expiry[i] != 0 && expiry[i] <= r.now_ms) begin
							vacate(i);
							e.expired_count++;
						end
					e.ok = 1'b1;
				end
				default: ;
			endcase
			e.active_count = live;
			awaited.push_back(e);
		endfunction

		function void report(string what, logic [127:0] want, logic [127:0] got);
			errors++;
			if (errors <= 10)
				$display("mismatch %0d: %s expected %h got %h", errors, what, want, got);
		endfunction

		function void check_result(sti_pkg::rsp_t got);
			sti_pkg::rsp_t e;
			if (awaited.size() == 0) begin
				report("unexpected beat", '0, got);
				return;
			end
			e = awaited.pop_front();
			if (got.ok !== e.ok) report("ok", e.ok, got.ok);
			if (got.resolved_sid !== e.resolved_sid)
				report("resolved_sid", e.resolved_sid, got.resolved_sid);
			if (got.synthetic !== e.synthetic) report("synthetic", e.synthetic, got.synthetic);
			if (got.slot_index !== e.slot_index) report("slot_index", e.slot_index, got.slot_index);
			if (got.expired_count !== e.expired_count)
				report("expired_count", e.expired_count, got.expired_count);
			if (got.active_count !== e.active_count)
				report("active_count", e.active_count, got.active_count);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	sti_pkg::req_t req;
	logic done;
	sti_pkg::rsp_t rsp;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	session_scoreboard sb;
	logic [63:0] clock_ms;
	logic [63:0] sid_pool [8];
	logic [31:0] ip_pool [6];
	bit steady;
	int idle_cycles = 0;

	session_table_intake_core #(.TABLE_SLOTS(SLOTS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(rsp);
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(99);
		if (steady || k < 40) return 0;
		if (k < 85) return $urandom_range(1, 3);
		if (k < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send(input sti_pkg::req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		req = r;
		do @(posedge clk); while (busy);
		sb.note_request(r);
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (2 * SLOTS + 8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] a, input logic [31:0] v);
		logic [31:0] want;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = a;
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		want = (a == ADDR_MODE) ? {31'd0, v[0]} : v;
		if (prdata !== want) sb.report("register readback", want, prdata);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (a == ADDR_MODE) sb.mode = v[0];
		else sb.tmo = v;
	endtask

	function automatic sti_pkg::req_t make_item();
		sti_pkg::req_t r;
		int k;
		k = $urandom_range(99);
		r = '0;
		r.now_ms = clock_ms;
		if (k < 58) begin
			r.req_type = sti_pkg::REQ_INGEST;
			case ($urandom_range(3))
				0: r.sess_id = '0;
				1: r.sess_id = sid_pool[$urandom_range(7)];
				2: r.sess_id = sb.srv[$urandom_range(SLOTS - 1)];
				default: r.sess_id = rand64();
			endcase
			k = $urandom_range(9);
			r.pkt_ver = (k < 4) ? 32'd0 : (k < 8) ? 32'(k - 3) : $urandom;
			r.pkt_form = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(2));
			k = $urandom_range(9);
			r.client_ip = (k == 0) ? 32'd0 : (k < 7) ? ip_pool[$urandom_range(5)] : $urandom;
			r.src_port = 16'($urandom);
			r.encrypted = 1'($urandom);
		end else if (k < 73) begin
			r.req_type = sti_pkg::REQ_RELEASE;
			k = $urandom_range(9);
			r.sess_id = (k < 7) ? sb.srv[$urandom_range(SLOTS - 1)] : (k < 8) ? 64'd0 : rand64();
		end else if (k < 88) begin
			r.req_type = sti_pkg::REQ_EXPIRE;
		end else if (k < 92) begin
			r = {REQ_UNKNOWN, rand64(), $urandom, 8'($urandom), $urandom, 16'($urandom),
				1'($urandom), rand64()};
		end else begin
			r = {2'($urandom), rand64(), $urandom, 8'($urandom), $urandom, 16'($urandom),
				1'($urandom), rand64()};
		end
		clock_ms = clock_ms + $urandom_range(0, 60);
		return r;
	endfunction

	initial begin
		logic [31:0] tmo_set [5];
		sti_pkg::req_t r;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		steady = 1'b0;
		clock_ms = 64'd1000;
		tmo_set = '{32'd300, 32'd700, 32'd0, 32'hFFFF_FFFF, 32'd1500};
		for (int i = 0; i < 8; i++) sid_pool[i] = (i < 4) ? 64'(i + 1) : rand64();
		for (int i = 0; i < 6; i++) ip_pool[i] = $urandom | 32'd1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: raw address hit, id wrap, release misses and a hit, unknown request, full table.
		r = '0;
		r.req_type = sti_pkg::REQ_INGEST;
		r.client_ip = 32'hC0A8_0001;
		send(r);
		send(r);
		r.sess_id = '1;
		r.pkt_ver = 32'd5;
		send(r);
		r.sess_id = '0;
		r.pkt_ver = 32'd7;
		r.client_ip = '0;
		send(r);
		r.sess_id = '1;
		r.pkt_ver = 32'd5;
		r.client_ip = 32'hC0A8_0001;
		send(r);
		r = '0;
		r.req_type = sti_pkg::REQ_RELEASE;
		send(r);
		r.sess_id = 64'd12345;
		send(r);
		r.sess_id = '1;
		send(r);
		send('1);
		for (int i = 0; i < 15; i++) begin
			r = '1;
			r.req_type = sti_pkg::REQ_INGEST;
			r.sess_id = 64'(100 + i);
			send(r);
		end
		r = '1;
		r.req_type = sti_pkg::REQ_EXPIRE;
		send(r);
		drain();

		for (int p = 0; p < 5; p++) begin
			write_reg(ADDR_MODE, {31'd0, p[0]});
			write_reg(ADDR_TIMEOUT, tmo_set[p]);
			if (tmo_set[p] == 0) begin
				r = '0;
				r.req_type = sti_pkg::REQ_INGEST;
				send(r);
				r.req_type = sti_pkg::REQ_EXPIRE;
				r.now_ms = 64'd5;
				send(r);
			end
			for (int n = 0; n < 240; n++) begin
				if (n % 60 == 0) steady = ($urandom_range(3) == 0);
				send(make_item());
			end
			steady = 1'b0;
			drain();
		end

		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire
